// ----- sv/plid_pkg.sv -----
// Shared types and constants for the positional list with insert and delete.
`default_nettype none

package plid_pkg;

  // Default geometry of the list.
  localparam int CAPACITY_DEF    = 128;
  localparam int ENTRY_WIDTH_DEF = 32;

  // Widest cell index the command bus carries (largest supported capacity is 1024).
  localparam int IDX_W_MAX = 10;

  // Number of cells folded together in the first level of the removal tree.
  localparam int GROUP_SIZE = 16;

  // Command codes on the cmd port.
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // Status codes on the status port.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_POS = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  // What every cell does in the current cycle.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INS,
    OP_DEL
  } cell_op_t;

  typedef struct packed {
    cell_op_t               op;
    logic [IDX_W_MAX-1:0]   idx;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- sv/plid_cell.sv -----
// One list cell: holds one entry and shifts toward either neighbor.
`default_nettype none

module plid_cell
  import plid_pkg::*;
#(
  parameter int INDEX       = 0,
  parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire cell_ctl_t              ctl,
  input  wire logic [ENTRY_WIDTH-1:0] ins_data,
  input  wire logic [ENTRY_WIDTH-1:0] left_val,
  input  wire logic [ENTRY_WIDTH-1:0] right_val,
  output logic      [ENTRY_WIDTH-1:0] val,
  output logic      [ENTRY_WIDTH-1:0] tap
);

  logic at_idx;
  logic above_idx;

  assign at_idx    = (ctl.idx == IDX_W_MAX'(INDEX));
  assign above_idx = (ctl.idx <  IDX_W_MAX'(INDEX));

  // A delete at this cell hands the old value to the removal tree.
  assign tap = (ctl.op == OP_DEL && at_idx) ? val : '0;

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_INS: begin
        if (at_idx) begin
          val <= ins_data;
        end else if (above_idx) begin
          val <= left_val;
        end
      end
      OP_DEL: begin
        if (at_idx || above_idx) begin
          val <= right_val;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/plid_collect.sv -----
// Two-level registered OR tree that gathers the removed entry from the cells.
`default_nettype none

module plid_collect
  import plid_pkg::*;
#(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic [CAPACITY*ENTRY_WIDTH-1:0] taps,
  output logic      [ENTRY_WIDTH-1:0]          removed
);

  localparam int NGROUP = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

  logic [ENTRY_WIDTH-1:0] group_or [NGROUP];

  // First level: each group register folds its cells in the accept cycle.
  for (genvar g = 0; g < NGROUP; g++) begin : g_grp
    logic [ENTRY_WIDTH-1:0] group_next;

    always_comb begin
      group_next = '0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        if (g * GROUP_SIZE + k < CAPACITY) begin
          group_next = group_next | taps[(g * GROUP_SIZE + k) * ENTRY_WIDTH +: ENTRY_WIDTH];
        end
      end
    end

    always_ff @(posedge clk) begin
      group_or[g] <= group_next;
    end
  end

  // Second level: fold the group registers; the caller registers the result.
  always_comb begin
    removed = '0;
    for (int g = 0; g < NGROUP; g++) begin
      removed = removed | group_or[g];
    end
  end

endmodule

`default_nettype wire

// ----- sv/positional_list_insert_delete.sv -----
// Top level of the positional list: command decode, cell chain and result registers.
`default_nettype none

// Ordered list of up to CAPACITY entry words, addressed by 1-based position.
// An item is taken when start is high and busy is low; it carries a command
// (insert, delete or clear), a position and, for insert, the entry word.
// Every item gives exactly one result, shown for one cycle with done high:
// status, the removed entry (zero unless a delete succeeded) and the list
// length after the operation. An accept sets pend, and pend sets done and
// the result registers. The receiver cannot stall, so results must be taken
// when done is high. busy is high in the cycle after an accept; the
// next item can be taken while the previous result is shown. The list is a
// chain of cells; those at and behind the position shift at the accept edge,
// and the registered OR tree then brings the deleted entry out. Entries need
// no clearing after reset: a delete only reads positions below the length.

module positional_list_insert_delete
  import plid_pkg::*;
#(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  cmd,
  input  wire logic [7:0]  position,
  input  wire logic [31:0] entry_data,
  output logic             done,
  output logic [1:0]       status,
  output logic [31:0]      removed_data,
  output logic [7:0]       list_length
);

  // Width of the length counter, of a cell index, and of position compares.
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMPW = ((CW > 8) ? CW : 8) + 1;
  // Common width for resizing entry words to and from the 32-bit ports.
  localparam int XW   = (ENTRY_WIDTH > 32) ? ENTRY_WIDTH : 32;

  logic            accept;
  logic            pend;
  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic [1:0]      st_q;
  logic [1:0]      st_next;
  logic [CMPW-1:0] pos_ext;
  logic [CMPW-1:0] cnt_ext;
  logic [CMPW-1:0] pos_m1;
  logic [CMPW-1:0] len_ext;
  cell_ctl_t       ctl;

  logic [XW-1:0]          data_x;
  logic [ENTRY_WIDTH-1:0] ins_data;
  logic [ENTRY_WIDTH-1:0] removed_ew;
  logic [XW-1:0]          removed_x;

  assign accept = start && !busy;
  assign busy   = pend;

  assign pos_ext = CMPW'(position);
  assign cnt_ext = CMPW'(count);
  assign pos_m1  = pos_ext - CMPW'(1);

  // Keep the low ENTRY_WIDTH bits of the incoming word.
  assign data_x   = XW'(entry_data);
  assign ins_data = data_x[ENTRY_WIDTH-1:0];

  // Decode the command against the current length. Cells only move when the
  // item is accepted and the command is legal; otherwise they hold.
  always_comb begin
    st_next    = ST_OK;
    count_next = count;
    ctl.op     = OP_HOLD;
    ctl.idx    = IDX_W_MAX'(pos_m1[IW-1:0]);
    unique case (cmd)
      CMD_INSERT: begin
        if (pos_ext == '0 || pos_ext > cnt_ext + CMPW'(1)) begin
          st_next = ST_BAD_POS;
        end else if (cnt_ext >= CMPW'(CAPACITY)) begin
          st_next = ST_FULL;
        end else begin
          ctl.op     = OP_INS;
          count_next = count + CW'(1);
        end
      end
      CMD_DELETE: begin
        if (pos_ext == '0 || pos_ext > cnt_ext) begin
          st_next = ST_BAD_POS;
        end else begin
          ctl.op     = OP_DEL;
          count_next = count - CW'(1);
        end
      end
      CMD_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
    if (!accept) begin
      ctl.op = OP_HOLD;
    end
  end

  // The chain of cells. Cell 0 has no left neighbor, and the last cell feeds
  // itself on a delete since nothing lies behind it.
  logic [ENTRY_WIDTH-1:0]          cell_val [CAPACITY];
  logic [CAPACITY*ENTRY_WIDTH-1:0] taps;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ENTRY_WIDTH-1:0] left_v;
    logic [ENTRY_WIDTH-1:0] right_v;

    if (i == 0) begin : g_first
      assign left_v = ins_data;
    end else begin : g_mid_l
      assign left_v = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_v = cell_val[i];
    end else begin : g_mid_r
      assign right_v = cell_val[i+1];
    end

    plid_cell #(
      .INDEX       (i),
      .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .ins_data  (ins_data),
      .left_val  (left_v),
      .right_val (right_v),
      .val       (cell_val[i]),
      .tap       (taps[i*ENTRY_WIDTH +: ENTRY_WIDTH])
    );
  end

  // The deleted entry reaches removed_ew in the cycle after the accept.
  plid_collect #(
    .CAPACITY    (CAPACITY),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_collect (
    .clk     (clk),
    .taps    (taps),
    .removed (removed_ew)
  );

  assign removed_x = XW'(removed_ew);
  assign len_ext   = CMPW'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      pend <= accept;
      done <= pend;
      if (accept) begin
        count <= count_next;
      end
    end
    if (accept) begin
      st_q <= st_next;
    end
    if (pend) begin
      status       <= st_q;
      removed_data <= removed_x[31:0];
      list_length  <= len_ext[7:0];
    end
  end

  // An accepted item always makes the block busy in the next cycle.
  assert property (@(posedge clk) disable iff (rst) accept |=> busy)
    else $error("busy did not rise after an accepted item");

  // Each accepted item sets pend, which then raises the result strobe done.
  assert property (@(posedge clk) disable iff (rst) accept |=> ##1 done)
    else $error("result strobe missing two cycles after accept");

  // While a result is shown the block is free for the next item.
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("busy high while a result is shown");

  // The length never exceeds the capacity.
  assert property (@(posedge clk) disable iff (rst) cnt_ext <= CMPW'(CAPACITY))
    else $error("list length beyond capacity");

  // A rejected item never returns an entry.
  assert property (@(posedge clk) disable iff (rst)
      (done && status != ST_OK) |-> removed_data == '0)
    else $error("entry returned on a failed command");

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the positional list with insert, delete and clear.
`timescale 1ns / 100ps

module tb;
  import plid_pkg::*;

  // The list geometry that the block is built with.
  localparam int LIST_CAP = CAPACITY_DEF;

  // The fourth command code has no function; the block must answer it with
  // an ok status and leave the list alone.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Cycles without any accepted item or result before the run is abandoned.
  localparam int STALL_LIMIT = 1000;

  // One expected result, as the block shows it on its result ports.
  typedef struct {
    logic [1:0]  status;
    logic [31:0] removed;
    logic [7:0]  length;
  } list_result_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  cmd;
  logic [7:0]  position;
  logic [31:0] entry_data;
  logic        done;
  logic [1:0]  status;
  logic [31:0] removed_data;
  logic [7:0]  list_length;

  // Our own copy of the list contents and its length.
  logic [31:0] shadow_list [LIST_CAP];
  int          shadow_count;

  // Results that the block still owes us, oldest first.
  list_result_t pending_results [$];

  // When set, the sender offers the next item right away with no gap.
  bit no_idle;

  int error_count;
  int n_inserts, n_deletes, n_clears, n_unused;
  int n_ok, n_bad_pos, n_full, peak_length;

  positional_list_insert_delete dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .position     (position),
    .entry_data   (entry_data),
    .done         (done),
    .status       (status),
    .removed_data (removed_data),
    .list_length  (list_length)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Apply one command to the shadow list and return what the block must
  // answer. The position is checked before the full condition, so an insert
  // at a bad position on a full list still reports a bad position.
  function automatic list_result_t apply_list_command(input logic [1:0] op,
                                                      input logic [7:0] pos_in,
                                                      input logic [31:0] word);
    list_result_t res;
    int           pos;
    pos         = int'(pos_in);
    res.status  = ST_OK;
    res.removed = '0;
    case (op)
      CMD_INSERT: begin
        n_inserts++;
        if (pos < 1 || pos > shadow_count + 1) begin
          res.status = ST_BAD_POS;
        end else if (shadow_count >= LIST_CAP) begin
          res.status = ST_FULL;
        end else begin
          // Everything at or behind the position moves one place up.
          for (int j = shadow_count; j > pos - 1; j--) begin
            shadow_list[j] = shadow_list[j-1];
          end
          shadow_list[pos-1] = word;
          shadow_count++;
        end
      end
      CMD_DELETE: begin
        n_deletes++;
        if (pos < 1 || pos > shadow_count) begin
          res.status = ST_BAD_POS;
        end else begin
          // The entry leaves and everything behind it closes the hole.
          res.removed = shadow_list[pos-1];
          for (int j = pos; j < shadow_count; j++) begin
            shadow_list[j-1] = shadow_list[j];
          end
          shadow_count--;
        end
      end
      CMD_CLEAR: begin
        n_clears++;
        shadow_count = 0;
      end
      default: begin
        n_unused++;
      end
    endcase
    res.length = shadow_count[7:0];
    case (res.status)
      ST_OK:      n_ok++;
      ST_BAD_POS: n_bad_pos++;
      default:    n_full++;
    endcase
    if (shadow_count > peak_length) begin
      peak_length = shadow_count;
    end
    return res;
  endfunction

  // Offer one item and hold it until the block takes it. The gap before the
  // item lowers start; with no gap start simply stays high, so it never gets
  // two assignments in the same time step. The expectation is recorded at the
  // edge that accepts the item.
  task automatic send_item(input logic [1:0] op, input logic [7:0] pos,
                           input logic [31:0] word);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    cmd        <= op;
    position   <= pos;
    entry_data <= word;
    do @(posedge clk); while (busy);
    pending_results.push_back(apply_list_command(op, pos, word));
  endtask

  // Entry words lean toward the all-zero and all-one extremes now and then.
  function automatic logic [31:0] pick_entry();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Small hand-picked sequence on an empty list: every command, every status
  // that an unfilled list can give, the position extremes and the data
  // extremes, with inserts and deletes at the front, middle and back.
  task automatic test_directed_commands();
    send_item(CMD_DELETE, 8'd1,   32'h0);          // delete on an empty list
    send_item(CMD_INSERT, 8'd0,   32'hDEAD_BEEF);  // position zero is never valid
    send_item(CMD_INSERT, 8'd2,   32'hDEAD_BEEF);  // beyond the append point
    send_item(CMD_INSERT, 8'd1,   32'h0000_0000);
    send_item(CMD_INSERT, 8'd2,   32'hFFFF_FFFF);  // append
    send_item(CMD_INSERT, 8'd1,   32'hA5A5_A5A5);  // front
    send_item(CMD_INSERT, 8'd2,   32'h5A5A_5A5A);  // middle
    send_item(CMD_INSERT, 8'd255, 32'h1234_5678);
    send_item(CMD_DELETE, 8'd0,   32'hFFFF_FFFF);
    send_item(CMD_DELETE, 8'd5,   32'h0);          // one past the last entry
    send_item(CMD_DELETE, 8'd255, 32'h0);
    send_item(CMD_DELETE, 8'd2,   32'h0);          // middle
    send_item(CMD_DELETE, 8'd3,   32'h0);          // last
    send_item(CMD_UNUSED, 8'd255, 32'hFFFF_FFFF);
    send_item(CMD_UNUSED, 8'd0,   32'h0);
    send_item(CMD_DELETE, 8'd1,   32'h0);          // first
    send_item(CMD_INSERT, 8'd2,   32'h8000_0001);
    send_item(CMD_CLEAR,  8'd255, 32'hFFFF_FFFF);
    send_item(CMD_DELETE, 8'd1,   32'h0);          // old entries are gone
    send_item(CMD_INSERT, 8'd1,   32'h1234_5678);
    send_item(CMD_DELETE, 8'd1,   32'h0);
    send_item(CMD_CLEAR,  8'd0,   32'h0);          // clear an empty list
  endtask

  // Fill the list to capacity at random positions, then probe the full
  // condition against the bad-position check and work at the top end.
  task automatic test_full_list();
    int n;
    n       = 0;
    no_idle = 1'b0;
    send_item(CMD_CLEAR, 8'd0, 32'h0);
    while (shadow_count < LIST_CAP) begin
      // Alternate between back-to-back items and items with gaps.
      no_idle = (n / 16) % 2 == 1;
      send_item(CMD_INSERT, 8'($urandom_range(1, shadow_count + 1)), pick_entry());
      n++;
    end
    no_idle = 1'b0;
    send_item(CMD_INSERT, 8'(LIST_CAP + 1), 32'hFFFF_FFFF);  // append point, full
    send_item(CMD_INSERT, 8'd1,             32'h0);           // front, full
    send_item(CMD_INSERT, 8'(LIST_CAP + 2), 32'h0);           // bad position wins
    send_item(CMD_INSERT, 8'd0,             32'h0);
    send_item(CMD_DELETE, 8'(LIST_CAP + 1), 32'h0);
    send_item(CMD_DELETE, 8'(LIST_CAP),     32'h0);           // last slot
    send_item(CMD_INSERT, 8'(LIST_CAP),     32'hC001_D00D);   // refill by appending
    send_item(CMD_DELETE, 8'd1,             32'h0);
    send_item(CMD_INSERT, 8'd1,             32'hFFFF_FFFF);
    send_item(CMD_DELETE, 8'(LIST_CAP / 2), 32'h0);
    send_item(CMD_DELETE, 8'(LIST_CAP - 1), 32'h0);
  endtask

  // Long random run. Each phase has its own insert share, so the length
  // wanders between empty and full. Most positions are valid; the rest are
  // zero or past the end. Clears and the unused code are rare.
  task automatic test_random_traffic(input int n_items);
    int ins_share;
    int r;
    int pos;
    logic [1:0] op;
    ins_share = 50;
    for (int i = 0; i < n_items; i++) begin
      if (i % 150 == 0) begin
        case ($urandom_range(0, 4))
          0:       ins_share = 85;
          1:       ins_share = 70;
          2:       ins_share = 50;
          3:       ins_share = 30;
          default: ins_share = 15;
        endcase
        no_idle = $urandom_range(0, 3) == 0;
      end
      r = $urandom_range(0, 999);
      if (r < 15) begin
        op = CMD_UNUSED;
      end else if (r < 18) begin
        op = CMD_CLEAR;
      end else if ($urandom_range(0, 99) < ins_share) begin
        op = CMD_INSERT;
      end else begin
        op = CMD_DELETE;
      end
      if ($urandom_range(0, 9) != 0) begin
        if (op == CMD_INSERT) begin
          pos = $urandom_range(1, shadow_count + 1);
        end else begin
          pos = shadow_count > 0 ? $urandom_range(1, shadow_count) : 1;
        end
      end else begin
        case ($urandom_range(0, 2))
          0:       pos = 0;
          1:       pos = 255;
          default: pos = $urandom_range(shadow_count + 2, 255);
        endcase
      end
      send_item(op, 8'(pos), pick_entry());
    end
  endtask

  // Every strobe must match the oldest outstanding expectation. Outputs are
  // sampled at the edge that ends the strobe cycle, before that edge's updates.
  always @(posedge clk) begin
    list_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: status %0d removed %h length %0d",
                 $time, status, removed_data, list_length);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, got %0d",
                   $time, want.status, status);
          error_count++;
        end
        if (removed_data !== want.removed) begin
          $display("%0t: removed_data mismatch: expected %h, got %h",
                   $time, want.removed, removed_data);
          error_count++;
        end
        if (list_length !== want.length) begin
          $display("%0t: list_length mismatch: expected %0d, got %0d",
                   $time, want.length, list_length);
          error_count++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither an item nor a result moves.
  always @(posedge clk) begin
    int quiet_cycles;
    if (rst || (start && !busy) || done) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, pending_results.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    cmd          = CMD_INSERT;
    position     = '0;
    entry_data   = '0;
    no_idle      = 1'b0;
    shadow_count = 0;
    error_count  = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_directed_commands();
    test_full_list();
    test_random_traffic(1780);

    // Stop offering items, collect whatever is still in flight, then keep the
    // clock running so that any stray result would still be seen.
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);

    $display("tb: ran %0d inserts, %0d deletes, %0d clears, %0d unused commands, peak length %0d",
             n_inserts, n_deletes, n_clears, n_unused, peak_length);
    $display("tb: statuses seen: ok %0d, bad position %0d, list full %0d",
             n_ok, n_bad_pos, n_full);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
